### rtl/core/ses_pkg.sv
// shared types and constants for the sprite evaluation sequencer
package ses_pkg;

	// sprite memory geometry
	localparam int unsigned SLOTS       = 8;
	localparam int unsigned SPRITES     = 64;
	localparam int unsigned SLOT_W      = $clog2(SLOTS);
	localparam int unsigned VISIBLE_END = 240;
	localparam int unsigned LAST_DOT    = 255;
	localparam int unsigned START_DOT   = 63;
	localparam int unsigned CLEAR_END   = 64;

	// field widths
	localparam int unsigned LINE_W   = 9;
	localparam int unsigned DOT_W    = 9;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SEC_W    = 5;
	localparam int unsigned HEIGHT_W = 5;
	localparam int unsigned SCAN_W   = 7;
	localparam int unsigned SLOTC_W  = 4;
	localparam int unsigned CFG_W    = 9;
	localparam int unsigned CFG_IDX_W = 2;

	// register reset values
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = HEIGHT_W'(8);
	localparam logic [LINE_W-1:0]   PRERENDER_RST = LINE_W'(261);

	// byte patterns
	localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] ALIGN_MASK = 8'hFC;
	localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'h03;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RENDER    = 2'd0,
		CFG_HEIGHT    = 2'd1,
		CFG_PRERENDER = 2'd2
	} cfg_idx_t;

	// evaluation phases
	typedef enum logic [3:0] {
		PH_CLEAR    = 4'd0,
		PH_COMPARE  = 4'd1,
		PH_COPY1    = 4'd2,
		PH_COPY2    = 4'd3,
		PH_COPY3    = 4'd4,
		PH_OVF_CMP  = 4'd5,
		PH_OVF1     = 4'd6,
		PH_OVF2     = 4'd7,
		PH_OVF3     = 4'd8,
		PH_DONE     = 4'd9
	} phase_t;

endpackage

### rtl/core/ses_dot_if.sv
// valid/ready channel carrying one dot item
interface ses_dot_if;
	logic                          valid;
	logic                          ready;
	logic [ses_pkg::LINE_W-1:0]    line;
	logic [ses_pkg::DOT_W-1:0]     dot;
	logic [ses_pkg::BYTE_W-1:0]    oam_data;

	modport source (output valid, output line, output dot, output oam_data, input ready);
	modport sink   (input valid, input line, input dot, input oam_data, output ready);
endinterface

### rtl/core/ses_result_if.sv
// valid/ready channel carrying one evaluation result
interface ses_result_if;
	logic                          valid;
	logic                          ready;
	logic [ses_pkg::BYTE_W-1:0]    oam_addr;
	logic                          sec_write;
	logic [ses_pkg::SEC_W-1:0]     sec_index;
	logic [ses_pkg::BYTE_W-1:0]    sec_data;
	logic                          overflow_flag;
	logic [ses_pkg::SLOTS-1:0]     zero_slot_flags;

	modport source (output valid, output oam_addr, output sec_write, output sec_index,
		output sec_data, output overflow_flag, output zero_slot_flags, input ready);
	modport sink   (input valid, input oam_addr, input sec_write, input sec_index,
		input sec_data, input overflow_flag, input zero_slot_flags, output ready);
endinterface

### rtl/core/sprite_evaluation_sequencer_unit.sv
// Sprite evaluation sequencer: takes one dot per transfer and returns one result per dot.
// An item is taken into an input register, evaluated against the sequencer state
// combinationally and loaded into the result register once that register is free, so one dot is
// accepted every cycle when the result side keeps up. The rate is set by the state
// update loop; while a finished result waits, the input register takes at most one
// more dot and then holds the input until the result leaves.
// Configuration may be written only while no dot is in flight.
module sprite_evaluation_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ses_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ses_pkg::CFG_W-1:0]         cfg_data,
	ses_dot_if.sink                           dot_item,
	ses_result_if.source                      result
);

	// configuration registers
	logic                              render_q;
	logic [ses_pkg::HEIGHT_W-1:0]      height_q;
	logic [ses_pkg::LINE_W-1:0]        prerender_q;

	// input stage
	logic                              valid_s1;
	logic [ses_pkg::LINE_W-1:0]        line_s1;
	logic [ses_pkg::DOT_W-1:0]         dot_s1;
	logic [ses_pkg::BYTE_W-1:0]        data_s1;

	// sequencer state
	ses_pkg::phase_t                   phase_q, phase_d;
	logic [ses_pkg::BYTE_W-1:0]        mem_addr_q, mem_addr_d;
	logic [ses_pkg::SLOTC_W-1:0]       slot_q, slot_d;
	logic [ses_pkg::SCAN_W-1:0]        scan_q, scan_d;
	logic                              fetch_q, fetch_d;
	logic [ses_pkg::BYTE_W-1:0]        fetched_q, fetched_d;
	logic                              overflow_q, overflow_d;
	logic [ses_pkg::SLOTS-1:0]         zero_q, zero_d;

	// result register
	logic                              out_valid_q;
	logic                              wr_d;
	logic [ses_pkg::SEC_W-1:0]         widx_d;
	logic [ses_pkg::BYTE_W-1:0]        wdat_d;
	logic                              wr_q;
	logic [ses_pkg::SEC_W-1:0]         widx_q;
	logic [ses_pkg::BYTE_W-1:0]        wdat_q;
	logic [ses_pkg::BYTE_W-1:0]        addr_q;

	logic                              advance;
	logic                              in_xfer;
	logic                              pre;
	logic                              active;
	logic                              covers;
	logic [ses_pkg::LINE_W-1:0]        y_ext;
	logic [ses_pkg::LINE_W-1:0]        diff;
	logic [ses_pkg::SLOT_W-1:0]        s;
	logic [ses_pkg::SCAN_W-1:0]        scan_inc;
	logic [ses_pkg::SLOTC_W-1:0]       slot_inc;
	logic [ses_pkg::BYTE_W-1:0]        diag;
	logic [ses_pkg::BYTE_W-1:0]        step8;

	// handshake: the input stage moves on whenever the result register is free
	assign advance        = valid_s1 && (!out_valid_q || result.ready);
	assign dot_item.ready = !valid_s1 || advance;
	assign in_xfer        = dot_item.valid && dot_item.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			render_q    <= 1'b0;
			height_q    <= ses_pkg::HEIGHT_RST;
			prerender_q <= ses_pkg::PRERENDER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ses_pkg::CFG_RENDER:    render_q    <= cfg_data[0];
				ses_pkg::CFG_HEIGHT:    height_q    <= cfg_data[ses_pkg::HEIGHT_W-1:0];
				ses_pkg::CFG_PRERENDER: prerender_q <= cfg_data[ses_pkg::LINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dot_item.ready) begin
			valid_s1 <= dot_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			line_s1 <= dot_item.line;
			dot_s1  <= dot_item.dot;
			data_s1 <= dot_item.oam_data;
		end
	end

	// sprite y range test against the current line
	assign y_ext  = {1'b0, fetched_q};
	assign diff   = line_s1 - y_ext;
	assign covers = (line_s1 >= y_ext) && (diff < {4'b0, height_q});

	assign pre      = (line_s1 == prerender_q);
	assign active   = render_q && ((line_s1 < ses_pkg::LINE_W'(ses_pkg::VISIBLE_END)) || pre)
		&& (dot_s1 <= ses_pkg::DOT_W'(ses_pkg::LAST_DOT));
	assign s        = slot_q[ses_pkg::SLOT_W-1:0];
	assign scan_inc = scan_q + ses_pkg::SCAN_W'(1);
	assign slot_inc = slot_q + ses_pkg::SLOTC_W'(1);
	// diagonal address step of overflow scan
	assign diag     = ((mem_addr_q + 8'd4) & ses_pkg::ALIGN_MASK)
		+ ((mem_addr_q + 8'd1) & ses_pkg::BYTE_MASK);

	// next state and write for one dot
	always_comb begin
		phase_d    = phase_q;
		mem_addr_d = mem_addr_q;
		slot_d     = slot_q;
		scan_d     = scan_q;
		fetch_d    = fetch_q;
		fetched_d  = fetched_q;
		overflow_d = overflow_q;
		zero_d     = zero_q;
		wr_d       = 1'b0;
		widx_d     = '0;
		wdat_d     = '0;
		step8      = mem_addr_q + 8'd1;

		if (pre && (dot_s1 == '0)) begin
			overflow_d = 1'b0;
		end

		if (active) begin
			if (!dot_s1[0]) begin
				fetched_d = fetch_q ? data_s1 : ses_pkg::EMPTY_BYTE;
			end else begin
				case (phase_q)
					ses_pkg::PH_CLEAR: begin
						if (dot_s1 <= ses_pkg::DOT_W'(ses_pkg::CLEAR_END)) begin
							wr_d   = 1'b1;
							widx_d = {dot_s1[5:3], dot_s1[2:1]};
							wdat_d = ses_pkg::EMPTY_BYTE;
							if (dot_s1[2:1] == 2'b11) begin
								zero_d[dot_s1[5:3]] = 1'b0;
							end
						end
					end
					ses_pkg::PH_COMPARE: begin
						if (!pre) begin
							scan_d = scan_inc;
							if (!covers) begin
								if (scan_inc != ses_pkg::SCAN_W'(ses_pkg::SPRITES)) begin
									mem_addr_d = (scan_inc != 7'd2) ? mem_addr_q + 8'd4 : 8'd8;
								end else begin
									mem_addr_d = '0;
									phase_d    = ses_pkg::PH_DONE;
								end
							end else begin
								mem_addr_d = mem_addr_q + 8'd1;
								phase_d    = ses_pkg::PH_COPY1;
								wr_d       = 1'b1;
								widx_d     = {s, 2'd0};
								wdat_d     = fetched_q;
								zero_d[s]  = (scan_inc == 7'd1);
							end
						end
					end
					ses_pkg::PH_COPY1: begin
						mem_addr_d = mem_addr_q + 8'd1;
						wr_d       = 1'b1;
						widx_d     = {s, 2'd1};
						wdat_d     = fetched_q;
						phase_d    = ses_pkg::PH_COPY2;
					end
					ses_pkg::PH_COPY2: begin
						mem_addr_d = mem_addr_q + 8'd1;
						wr_d       = 1'b1;
						widx_d     = {s, 2'd2};
						wdat_d     = fetched_q;
						phase_d    = ses_pkg::PH_COPY3;
					end
					ses_pkg::PH_COPY3: begin
						wr_d   = 1'b1;
						widx_d = {s, 2'd3};
						wdat_d = fetched_q;
						slot_d = slot_inc;
						if (scan_q != ses_pkg::SCAN_W'(ses_pkg::SPRITES)) begin
							phase_d = (slot_inc != ses_pkg::SLOTC_W'(ses_pkg::SLOTS))
								? ses_pkg::PH_COMPARE : ses_pkg::PH_OVF_CMP;
							mem_addr_d = (scan_q != 7'd2) ? mem_addr_q + 8'd1 : 8'd8;
						end else begin
							mem_addr_d = '0;
							phase_d    = ses_pkg::PH_DONE;
						end
					end
					ses_pkg::PH_OVF_CMP: begin
						if (!pre) begin
							if (!covers) begin
								if (diag <= 8'd5) begin
									phase_d    = ses_pkg::PH_DONE;
									mem_addr_d = diag & ses_pkg::ALIGN_MASK;
								end else begin
									mem_addr_d = diag;
								end
							end else begin
								phase_d    = ses_pkg::PH_OVF1;
								mem_addr_d = mem_addr_q + 8'd1;
								overflow_d = 1'b1;
							end
						end
					end
					ses_pkg::PH_OVF1: begin
						phase_d    = ses_pkg::PH_OVF2;
						mem_addr_d = mem_addr_q + 8'd1;
					end
					ses_pkg::PH_OVF2: begin
						phase_d    = ses_pkg::PH_OVF3;
						mem_addr_d = mem_addr_q + 8'd1;
					end
					ses_pkg::PH_OVF3: begin
						phase_d = ses_pkg::PH_DONE;
						if (step8[1:0] == 2'b11) begin
							step8 = step8 + 8'd1;
						end
						mem_addr_d = step8 & ses_pkg::ALIGN_MASK;
					end
					ses_pkg::PH_DONE: begin
						mem_addr_d = mem_addr_q + 8'd4;
					end
					default: begin
					end
				endcase
			end

			// evaluation start and end of the visible dots
			if (dot_s1 == ses_pkg::DOT_W'(ses_pkg::START_DOT)) begin
				fetch_d = 1'b1;
				phase_d = ses_pkg::PH_COMPARE;
				slot_d  = '0;
				scan_d  = '0;
			end
			if (dot_s1 == ses_pkg::DOT_W'(ses_pkg::LAST_DOT)) begin
				fetch_d    = 1'b0;
				phase_d    = ses_pkg::PH_CLEAR;
				slot_d     = '0;
				mem_addr_d = '0;
				scan_d     = '0;
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ses_pkg::PH_CLEAR;
			mem_addr_q <= '0;
			slot_q     <= '0;
			scan_q     <= '0;
			fetch_q    <= 1'b0;
			fetched_q  <= '0;
			overflow_q <= 1'b0;
			zero_q     <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			mem_addr_q <= mem_addr_d;
			slot_q     <= slot_d;
			scan_q     <= scan_d;
			fetch_q    <= fetch_d;
			fetched_q  <= fetched_d;
			overflow_q <= overflow_d;
			zero_q     <= zero_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_q   <= wr_d;
			widx_q <= widx_d;
			wdat_q <= wdat_d;
			addr_q <= mem_addr_d;
		end
	end

	// the flag outputs follow the state register, which loads with the result
	assign result.valid           = out_valid_q;
	assign result.oam_addr        = addr_q;
	assign result.sec_write       = wr_q;
	assign result.sec_index       = widx_q;
	assign result.sec_data        = wdat_q;
	assign result.overflow_flag   = overflow_q;
	assign result.zero_slot_flags = zero_q;

endmodule

### rtl/core/ses_checker.sv
// port-level checks for the sprite evaluation sequencer, bound to the top level
module ses_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          sec_write,
	input  logic [ses_pkg::SEC_W-1:0]     sec_index,
	input  logic [ses_pkg::BYTE_W-1:0]    sec_data,
	input  logic [ses_pkg::BYTE_W-1:0]    oam_addr
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(oam_addr) && $stable(sec_data))
		else $error("stalled result changed");

	// no write means a zero index and zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sec_write |-> sec_index == '0 && sec_data == '0)
		else $error("idle write fields not zero");

	// an empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result register");

	// every transfer is followed by a valid result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result missing after transfer");

endmodule

bind sprite_evaluation_sequencer_unit ses_checker u_ses_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (dot_item.valid),
	.in_ready  (dot_item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.sec_write (result.sec_write),
	.sec_index (result.sec_index),
	.sec_data  (result.sec_data),
	.oam_addr  (result.oam_addr)
);

### sim/tb.sv
// testbench for the sprite evaluation sequencer unit
`timescale 1ns / 1ps

module tb;
	import ses_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	// one evaluation result as the block returns it
	typedef struct packed {
		logic [BYTE_W-1:0] oam_addr;
		logic              sec_write;
		logic [SEC_W-1:0]  sec_index;
		logic [BYTE_W-1:0] sec_data;
		logic              overflow_flag;
		logic [SLOTS-1:0]  zero_slot_flags;
	} eval_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ses_dot_if    dot_bus ();
	ses_result_if res_bus ();

	sprite_evaluation_sequencer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dot_item  (dot_bus),
		.result    (res_bus)
	);

	// register copies
	logic                cfg_render;
	logic [HEIGHT_W-1:0] cfg_height;
	logic [LINE_W-1:0]   cfg_pre;

	// sequencer state copies
	phase_t              ev_phase;
	logic [BYTE_W-1:0]   ev_addr;
	logic [SLOTC_W-1:0]  ev_slot;
	logic [SCAN_W-1:0]   ev_scan;
	logic                ev_fetch;
	logic [BYTE_W-1:0]   ev_byte;
	logic                ev_ovf;
	logic [SLOTS-1:0]    ev_zero;

	// primary sprite memory image and the address the block last pointed at
	logic [BYTE_W-1:0]   oam_mem [256];
	logic [BYTE_W-1:0]   last_addr;

	eval_result_t        pending_results [$];
	int unsigned         mismatch_count;
	int unsigned         cycle_count;
	bit                  idle_on;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("sprite_evaluation_sequencer_unit test failed");
				$finish;
			end
		end
	end

	// y range check against the current line
	function automatic logic sprite_on_line(logic [LINE_W-1:0] ln, logic [BYTE_W-1:0] y);
		return (ln >= {1'b0, y}) && ((ln - {1'b0, y}) < {4'b0, cfg_height});
	endfunction

	// advance the sequencer copy by one dot and return what the block should output
	function automatic eval_result_t predict_dot(logic [LINE_W-1:0] ln, logic [DOT_W-1:0] dt,
			logic [BYTE_W-1:0] dat);
		eval_result_t r;
		logic         pre;
		logic [2:0]   s;
		logic         hit;
		r   = '0;
		pre = (ln == cfg_pre);
		s   = ev_slot[2:0];
		if (pre && dt == 0)
			ev_ovf = 1'b0;
		if (cfg_render && (ln < VISIBLE_END || pre) && dt <= LAST_DOT) begin
			if (!dt[0]) begin
				ev_byte = ev_fetch ? dat : EMPTY_BYTE;
			end else begin
				hit = sprite_on_line(ln, ev_byte);
				case (ev_phase)
					PH_CLEAR: begin
						if (dt <= CLEAR_END) begin
							r.sec_write = 1'b1;
							r.sec_index = {dt[5:3], dt[2:1]};
							r.sec_data  = EMPTY_BYTE;
							if (dt[2:1] == 2'd3)
								ev_zero[dt[5:3]] = 1'b0;
						end
					end
					PH_COMPARE: begin
						if (!pre) begin
							ev_scan = ev_scan + SCAN_W'(1);
							if (!hit) begin
								if (ev_scan != SPRITES) begin
									ev_addr = (ev_scan != 2) ? ev_addr + 8'd4 : 8'd8;
								end else begin
									ev_addr  = '0;
									ev_phase = PH_DONE;
								end
							end else begin
								ev_addr     = ev_addr + 8'd1;
								ev_phase    = PH_COPY1;
								r.sec_write = 1'b1;
								r.sec_index = {s, 2'd0};
								r.sec_data  = ev_byte;
								ev_zero[s]  = (ev_scan == 1);
							end
						end
					end
					PH_COPY1, PH_COPY2: begin
						ev_addr     = ev_addr + 8'd1;
						r.sec_write = 1'b1;
						r.sec_index = {s, 2'(ev_phase - 1)};
						r.sec_data  = ev_byte;
						ev_phase    = phase_t'(ev_phase + 1);
					end
					PH_COPY3: begin
						r.sec_write = 1'b1;
						r.sec_index = {s, 2'd3};
						r.sec_data  = ev_byte;
						ev_slot     = ev_slot + SLOTC_W'(1);
						if (ev_scan != SPRITES) begin
							ev_phase = (ev_slot != SLOTS) ? PH_COMPARE : PH_OVF_CMP;
							ev_addr  = (ev_scan != 2) ? ev_addr + 8'd1 : 8'd8;
						end else begin
							ev_addr  = '0;
							ev_phase = PH_DONE;
						end
					end
					PH_OVF_CMP: begin
						if (!pre) begin
							if (!hit) begin
								// diagonal step: entry and byte index both advance
								ev_addr = ((ev_addr + 8'd4) & ALIGN_MASK)
									+ ((ev_addr + 8'd1) & BYTE_MASK);
								if (ev_addr <= 5) begin
									ev_phase = PH_DONE;
									ev_addr  = ev_addr & ALIGN_MASK;
								end
							end else begin
								ev_phase = PH_OVF1;
								ev_addr  = ev_addr + 8'd1;
								ev_ovf   = 1'b1;
							end
						end
					end
					PH_OVF1, PH_OVF2: begin
						ev_phase = phase_t'(ev_phase + 1);
						ev_addr  = ev_addr + 8'd1;
					end
					PH_OVF3: begin
						ev_phase = PH_DONE;
						ev_addr  = ev_addr + 8'd1;
						if (ev_addr[1:0] == 2'd3)
							ev_addr = ev_addr + 8'd1;
						ev_addr = ev_addr & ALIGN_MASK;
					end
					PH_DONE: begin
						ev_addr = ev_addr + 8'd4;
					end
					default: begin
					end
				endcase
			end
			if (dt == START_DOT) begin
				ev_fetch = 1'b1;
				ev_phase = PH_COMPARE;
				ev_slot  = '0;
				ev_scan  = '0;
			end
			if (dt == LAST_DOT) begin
				ev_fetch = 1'b0;
				ev_phase = PH_CLEAR;
				ev_slot  = '0;
				ev_addr  = '0;
				ev_scan  = '0;
			end
		end
		r.oam_addr        = ev_addr;
		r.overflow_flag   = ev_ovf;
		r.zero_slot_flags = ev_zero;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// compare one result transfer with the oldest prediction
	task automatic check_result();
		eval_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result transfer with no dot pending");
			return;
		end
		want = pending_results.pop_front();
		if (res_bus.oam_addr !== want.oam_addr)
			report_mismatch($sformatf("oam_addr got %0h want %0h", res_bus.oam_addr,
				want.oam_addr));
		if (res_bus.sec_write !== want.sec_write)
			report_mismatch($sformatf("sec_write got %0b want %0b", res_bus.sec_write,
				want.sec_write));
		if (res_bus.sec_index !== want.sec_index)
			report_mismatch($sformatf("sec_index got %0d want %0d", res_bus.sec_index,
				want.sec_index));
		if (res_bus.sec_data !== want.sec_data)
			report_mismatch($sformatf("sec_data got %0h want %0h", res_bus.sec_data,
				want.sec_data));
		if (res_bus.overflow_flag !== want.overflow_flag)
			report_mismatch($sformatf("overflow_flag got %0b want %0b", res_bus.overflow_flag,
				want.overflow_flag));
		if (res_bus.zero_slot_flags !== want.zero_slot_flags)
			report_mismatch($sformatf("zero_slot_flags got %0h want %0h",
				res_bus.zero_slot_flags, want.zero_slot_flags));
	endtask

	// result side: random stall bursts, sample at the falling edge
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 5);
			if (stall_left > 0) begin
				res_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				res_bus.ready <= 1'b1;
			end
			@(negedge clk);
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
				check_result();
		end
	end

	// send one dot, predict its result once the transfer happens
	task automatic send_dot(input logic [LINE_W-1:0] ln, input logic [DOT_W-1:0] dt,
			input logic [BYTE_W-1:0] dat);
		eval_result_t r;
		logic         taken;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			dot_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		dot_bus.valid    <= 1'b1;
		dot_bus.line     <= ln;
		dot_bus.dot      <= dt;
		dot_bus.oam_data <= dat;
		do begin
			@(negedge clk);
			taken = (dot_bus.ready === 1'b1);
			@(posedge clk);
		end while (!taken);
		r = predict_dot(ln, dt, dat);
		last_addr = r.oam_addr;
		pending_results.push_back(r);
	endtask

	// dot whose memory byte follows the address from the previous result
	task automatic send_fetch(input logic [LINE_W-1:0] ln, input logic [DOT_W-1:0] dt);
		send_dot(ln, dt, oam_mem[last_addr]);
	endtask

	// stop sending and wait until every pending result has come back
	task automatic drain_results();
		dot_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_RENDER:    cfg_render = val[0];
			CFG_HEIGHT:    cfg_height = val[HEIGHT_W-1:0];
			CFG_PRERENDER: cfg_pre    = val[LINE_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic render, input int unsigned height,
			input int unsigned pre);
		drain_results();
		write_cfg(CFG_RENDER, CFG_W'(render));
		write_cfg(CFG_HEIGHT, CFG_W'(height));
		write_cfg(CFG_PRERENDER, CFG_W'(pre));
	endtask

	// fill sprite memory, placing about pct percent of the sprites at or just above the line
	task automatic fill_sprites(input int unsigned ln, input int unsigned pct);
		int unsigned k;
		for (int i = 0; i < 256; i++)
			oam_mem[i] = BYTE_W'($urandom);
		for (int sp = 0; sp < SPRITES; sp++) begin
			if ($urandom_range(0, 99) < pct) begin
				k = $urandom_range(0, cfg_height + 1);
				oam_mem[sp * 4] = (ln >= k) ? BYTE_W'(ln - k) : 8'd0;
			end
		end
	endtask

	// one well-formed line: dots 0 to 255 in order, then eight out-of-range dots
	task automatic run_line(input int unsigned ln, input int pause_at);
		for (int d = 0; d <= LAST_DOT; d++) begin
			send_fetch(LINE_W'(ln), DOT_W'(d));
			if (d == pause_at)
				drain_results();
		end
		repeat (8) send_fetch(LINE_W'(ln), DOT_W'($urandom_range(256, 340)));
	endtask

	function automatic int unsigned pick_density();
		case ($urandom_range(0, 3))
			0:       return 4;
			1:       return 15;
			default: return 40;
		endcase
	endfunction

	// rendering off after reset: nothing moves
	task automatic test_render_off();
		send_dot(LINE_W'(261), 9'd0, 8'h00);
		send_dot(9'd0, 9'd0, 8'hFF);
		send_dot(9'd311, 9'd340, 8'hFF);
		send_dot(9'd100, 9'd63, 8'h00);
		send_dot(9'd100, 9'd65, 8'h55);
		send_dot(9'd0, 9'd255, 8'hAA);
	endtask

	// field extremes and the start, reset and out-of-range dots
	task automatic test_field_extremes();
		set_config(1'b1, 8, 261);
		send_dot(9'd240, 9'd1, 8'h00);
		send_dot(9'd300, 9'd63, 8'hFF);
		send_dot(9'd0, 9'd256, 8'hFF);
		send_dot(9'd0, 9'd340, 8'h00);
		send_dot(9'd0, 9'd0, 8'h12);
		send_dot(9'd0, 9'd1, 8'h00);
		send_dot(9'd0, 9'd7, 8'hFF);
		send_dot(9'd0, 9'd63, 8'h00);
		send_dot(9'd0, 9'd64, 8'h00);
		send_dot(9'd0, 9'd65, 8'hFF);
		send_dot(9'd0, 9'd66, 8'hFF);
		send_dot(9'd0, 9'd67, 8'h00);
		send_dot(9'd239, 9'd68, 8'hEF);
		send_dot(9'd239, 9'd69, 8'h10);
		send_dot(9'd0, 9'd255, 8'hFF);
		send_dot(9'd261, 9'd0, 8'h00);
		send_dot(9'd311, 9'd1, 8'hFF);
	endtask

	// short sprites, with one full stop mid line
	task automatic test_short_sprites();
		int unsigned ln;
		set_config(1'b1, 8, 261);
		for (int n = 0; n < 1; n++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			ln = $urandom_range(0, 239);
			fill_sprites(ln, pick_density());
			run_line(ln, (n == 0) ? 130 : -1);
		end
	endtask

	// tall sprites on a long frame, overflow cleared at prerender start
	task automatic test_tall_sprites();
		int unsigned ln;
		set_config(1'b1, 16, 311);
		idle_on = 1'b1;
		ln = $urandom_range(0, 239);
		fill_sprites(ln, 40);
		run_line(ln, -1);
		fill_sprites(0, 50);
		run_line(311, -1);
	endtask

	// overflow clear with rendering off, then an odd height and prerender line
	task automatic test_prerender_clear();
		int unsigned ln;
		int unsigned pre;
		pre = $urandom_range(262, 310);
		ln  = $urandom_range(0, 239);
		set_config(1'b1, 8, pre);
		fill_sprites(ln, 45);
		run_line(ln, -1);
		drain_results();
		write_cfg(CFG_RENDER, CFG_W'(0));
		send_dot(LINE_W'(pre), 9'd0, 8'hFF);
		send_dot(LINE_W'(pre), 9'd1, 8'h00);
		set_config(1'b1, $urandom_range(9, 15), pre);
		ln = $urandom_range(0, 239);
		fill_sprites(ln, pick_density());
		run_line(ln, -1);
	endtask

	// random fields and lines that start late or skip dots
	task automatic test_noise_and_broken();
		int unsigned ln;
		int unsigned d;
		set_config(1'b1, 8, 261);
		idle_on = 1'b1;
		repeat (60)
			send_dot(LINE_W'($urandom_range(0, 311)), DOT_W'($urandom_range(0, 340)),
				BYTE_W'($urandom));
		repeat (2) begin
			ln = $urandom_range(0, 239);
			fill_sprites(ln, 40);
			d = $urandom_range(40, 120);
			while (d <= LAST_DOT) begin
				if ($urandom_range(0, 5) == 0)
					send_dot(LINE_W'(ln), DOT_W'(d), BYTE_W'($urandom));
				else
					send_fetch(LINE_W'(ln), DOT_W'(d));
				d += $urandom_range(1, 3);
			end
		end
	endtask

	// a last line with no idling on either side
	task automatic test_back_to_back();
		int unsigned ln;
		set_config(1'b1, 16, 261);
		idle_on = 1'b0;
		ln = $urandom_range(0, 239);
		fill_sprites(ln, 40);
		run_line(ln, -1);
	endtask

	// stimulus sequence
	initial begin
		mismatch_count = 0;
		idle_on        = 1'b1;
		last_addr      = '0;
		cfg_render     = 1'b0;
		cfg_height     = HEIGHT_RST;
		cfg_pre        = PRERENDER_RST;
		ev_phase       = PH_CLEAR;
		ev_addr        = '0;
		ev_slot        = '0;
		ev_scan        = '0;
		ev_fetch       = 1'b0;
		ev_byte        = '0;
		ev_ovf         = 1'b0;
		ev_zero        = '0;
		for (int i = 0; i < 256; i++)
			oam_mem[i] = '0;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_RENDER;
		cfg_data         <= '0;
		dot_bus.valid    <= 1'b0;
		dot_bus.line     <= '0;
		dot_bus.dot      <= '0;
		dot_bus.oam_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_render_off();
		test_field_extremes();
		test_short_sprites();
		test_tall_sprites();
		test_prerender_clear();
		test_noise_and_broken();
		test_back_to_back();

		drain_results();
		if (mismatch_count == 0)
			$display("sprite_evaluation_sequencer_unit test passed");
		else
			$display("sprite_evaluation_sequencer_unit test failed");
		$finish;
	end

endmodule

### sprite_evaluation_sequencer_unit.f
rtl/core/ses_pkg.sv
rtl/core/ses_dot_if.sv
rtl/core/ses_result_if.sv
rtl/core/sprite_evaluation_sequencer_unit.sv
rtl/core/ses_checker.sv
sim/tb.sv
